// File: rtl/sha_pkg.sv
// shared types, constants and sigma functions of the sha-256 byte stream hasher
// no dependencies; used by sha_msg_sched, sha_round and sha256_byte_stream_hasher
package sha_pkg;

  // working variables a..h, element 0 is a
  typedef logic [7:0][31:0] hash_t;

  // control from the sequencer to the message schedule
  typedef struct packed {
    logic push;      // one byte enters the block buffer
    logic word_end;  // that byte completes a 32-bit word
    logic step;      // advance the schedule by one round
  } msg_ctrl_t;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // round function sigma on a
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // round function sigma on e
  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // schedule sigma on w[t-15]
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // schedule sigma on w[t-2]
  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// File: rtl/sha_msg_sched.sv
// block buffer and message schedule: 16-word shift line fed by bytes, then
// extended in place one word per round; depends on sha_pkg
module sha_msg_sched (
  input  logic                  clk_i,
  input  sha_pkg::msg_ctrl_t    ctrl_i,
  input  logic [7:0]            byte_i,
  output logic [31:0]           wt_o
);

  logic [23:0] acc_q;
  logic [31:0] w_q [16];
  logic [31:0] next_w;

  // expanded word for round t+16
  assign next_w = sha_pkg::small_sigma1(w_q[14]) + w_q[9]
                + sha_pkg::small_sigma0(w_q[1]) + w_q[0];

  assign wt_o = w_q[0];

  // byte packing, big-endian within the word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      acc_q <= {acc_q[15:0], byte_i};
    end
  end

  // shift line: loads whole words, then runs the schedule
  always_ff @(posedge clk_i) begin
    if ((ctrl_i.push && ctrl_i.word_end) || ctrl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= ctrl_i.step ? next_w : {acc_q, byte_i};
    end
  end

endmodule

// File: rtl/sha_round.sv
// one sha-256 compression round, reused for all 64 rounds of a block
// depends on sha_pkg
module sha_round (
  input  sha_pkg::hash_t  v_i,
  input  logic [31:0]     k_i,
  input  logic [31:0]     w_i,
  output sha_pkg::hash_t  v_o
);

  logic [31:0] ch;
  logic [31:0] mj;
  logic [31:0] t1;
  logic [31:0] t2;

  // choose and majority
  assign ch = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
  assign mj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);

  assign t1 = v_i[7] + sha_pkg::big_sigma1(v_i[4]) + ch + k_i + w_i;
  assign t2 = sha_pkg::big_sigma0(v_i[0]) + mj;

  // rotate the working variables
  assign v_o[0] = t1 + t2;
  assign v_o[1] = v_i[0];
  assign v_o[2] = v_i[1];
  assign v_o[3] = v_i[2];
  assign v_o[4] = v_i[3] + t1;
  assign v_o[5] = v_i[4];
  assign v_o[6] = v_i[5];
  assign v_o[7] = v_i[6];

endmodule

// File: rtl/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream: one byte per input transfer, ending with a byte
// marked final. Every 64th byte then starts the block compression: the 64 rounds on the
// single shared round unit, then a fold of the result into the chaining value. The final
// byte is followed by padding pushed one byte per cycle through the same buffer (with one
// extra block when fewer than 9 bytes stay free) with one or two further compressions, and
// then the eight digest words leave as eight output transfers, word 0 first. in_ready_o is
// low during compression, padding and digest output. The hash restarts from the initial
// values after the last digest word. Depends on sha_pkg, sha_msg_sched and sha_round.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  message_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StAdd,
    StOut
  } state_e;

  state_e             state_q;
  sha_pkg::hash_t     chain_q;
  sha_pkg::hash_t     v_q;
  sha_pkg::hash_t     v_next;
  sha_pkg::hash_t     chain_sum;
  logic [5:0]         fill_q;
  logic [60:0]        byte_cnt_q;
  logic [5:0]         round_q;
  logic               pad_q;
  logic               first_q;
  logic               len_ok_q;
  logic               last_blk_q;
  logic [2:0]         out_idx_q;
  logic               in_xfer;
  logic               load_v;
  logic [63:0]        len_shift;
  logic [7:0]         pad_byte;
  logic [7:0]         push_byte;
  logic [31:0]        wt;
  sha_pkg::msg_ctrl_t msg_ctrl;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;

  // bit length, byte j of the big-endian field at pad positions 56..63
  assign len_shift = {byte_cnt_q, 3'b000} << {fill_q[2:0], 3'b000};

  // padding byte: marker, then zeros, length in the closing block
  always_comb begin
    priority if (first_q) begin
      pad_byte = sha_pkg::PAD_MARK;
    end else if (len_ok_q && (fill_q >= sha_pkg::LEN_START)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'd0;
    end
  end

  assign push_byte = (state_q == StPad) ? pad_byte : message_byte_i;

  // schedule control
  assign msg_ctrl.push     = in_xfer || (state_q == StPad);
  assign msg_ctrl.word_end = (fill_q[1:0] == 2'b11);
  assign msg_ctrl.step     = (state_q == StRound);

  // buffer is full once the byte at the last position enters
  assign load_v = msg_ctrl.push && (fill_q == sha_pkg::LAST_POS);

  sha_msg_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (msg_ctrl),
    .byte_i (push_byte),
    .wt_o   (wt)
  );

  sha_round u_round (
    .v_i (v_q),
    .k_i (sha_pkg::ROUND_K[round_q]),
    .w_i (wt),
    .v_o (v_next)
  );

  // fold the working variables into the chaining value
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sum[i] = chain_q[i] + v_q[i];
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (load_v) begin
      v_q <= chain_q;
    end else if (state_q == StRound) begin
      v_q <= v_next;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      chain_q    <= sha_pkg::INIT_HASH;
      fill_q     <= '0;
      byte_cnt_q <= '0;
      round_q    <= '0;
      pad_q      <= 1'b0;
      first_q    <= 1'b0;
      len_ok_q   <= 1'b0;
      last_blk_q <= 1'b0;
      out_idx_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            fill_q     <= fill_q + 6'd1;
            byte_cnt_q <= byte_cnt_q + 61'd1;
            pad_q      <= final_byte_i;
            first_q    <= final_byte_i;
            len_ok_q   <= 1'b0;
            last_blk_q <= 1'b0;
            round_q    <= '0;
            if (fill_q == sha_pkg::LAST_POS) begin
              state_q <= StRound;
            end else if (final_byte_i) begin
              state_q <= StPad;
            end
          end
        end
        StPad: begin
          fill_q  <= fill_q + 6'd1;
          first_q <= 1'b0;
          if (fill_q == sha_pkg::LAST_POS) begin
            state_q    <= StRound;
            round_q    <= '0;
            len_ok_q   <= 1'b1;
            last_blk_q <= len_ok_q;
          end else if (first_q) begin
            len_ok_q <= (fill_q < sha_pkg::LEN_START);
          end
        end
        StRound: begin
          round_q <= round_q + 6'd1;
          if (round_q == sha_pkg::LAST_ROUND) begin
            state_q <= StAdd;
          end
        end
        StAdd: begin
          chain_q <= chain_sum;
          priority if (last_blk_q) begin
            state_q   <= StOut;
            out_idx_q <= '0;
          end else if (pad_q) begin
            state_q <= StPad;
          end else begin
            state_q <= StIdle;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            out_idx_q <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              state_q    <= StIdle;
              chain_q    <= sha_pkg::INIT_HASH;
              byte_cnt_q <= '0;
              pad_q      <= 1'b0;
              last_blk_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // digest output
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = chain_q[out_idx_q];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 3'd7);

  // input and output never open together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest is pending");

  // digest words come in order without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=>
      (out_valid_o && (word_index_o == $past(word_index_o) + 3'd1)))
    else $error("digest word sequence broken");

  // the last word ends the digest and reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (!out_valid_o && in_ready_o))
    else $error("digest did not end after the last word");

  // an input byte that fills the buffer always starts a compression
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (fill_q == sha_pkg::LAST_POS)) |=> (state_q == StRound && round_q == 6'd0))
    else $error("full block not compressed");

endmodule

// File: bench/sha256_byte_stream_hasher_test.sv
// self-checking bench for sha256_byte_stream_hasher: byte messages in, digest words out
// carries its own sha-256 model; needs only the rtl (sha_pkg, sha_msg_sched, sha_round and the hasher top)
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_OFFSET = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned SHORT_BYTES = 1;

  localparam logic [0:7][31:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // well-known digest of the three-byte message "abc"
  localparam logic [0:7][31:0] ABC_DIGEST = {
    32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
    32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last_flag;
  } digest_word_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             fin;
    logic             known;
    logic [0:7][31:0] digest;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  message_byte_i;
  logic        final_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // model state: chaining value, block bytes, fill level, message length in bits
  logic [0:7][31:0] chain_val;
  logic [7:0]       blk_bytes [BLOCK_BYTES];
  int unsigned      fill_cnt;
  logic [63:0]      bit_len;

  digest_word_t pending_words [$];
  digest_word_t exp_w;
  stim_row_t    directed_rows [$];

  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned messages_done = 0;
  int unsigned words_checked = 0;
  int unsigned stuck_cycles = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  bit          hold_req = 1'b0;

  sha256_byte_stream_hasher u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_byte_i (message_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64 rounds over the current block, folded into the chaining value
  function automatic void sha_compress();
    logic [0:63][31:0] w;
    logic [0:7][31:0]  v;
    logic [31:0]       s0, s1, ch, mj, t1, t2;
    int unsigned       r;
    for (r = 0; r < 16; r++) begin
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    end
    for (r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    v = chain_val;
    for (r = 0; r < 64; r++) begin
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch + SHA_K[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
      v = {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
    end
    for (r = 0; r < 8; r++) begin
      chain_val[r] = chain_val[r] + v[r];
    end
  endfunction

  // takes one message byte; returns 1 with the digest when the byte ends a message
  function automatic bit absorb_byte(input logic [7:0] data, input logic fin,
                                     output logic [0:7][31:0] dig);
    int unsigned pos;
    int unsigned k;
    dig = '0;
    blk_bytes[fill_cnt] = data;
    fill_cnt++;
    // length is 64 bits and wraps, far beyond what a run can reach
    bit_len += 64'd8;
    if (fill_cnt == BLOCK_BYTES) begin
      sha_compress();
      fill_cnt = 0;
    end
    if (!fin) begin
      return 1'b0;
    end
    // marker byte, zeros, and a second block when the length no longer fits
    blk_bytes[fill_cnt] = PAD_BYTE;
    pos = fill_cnt + 1;
    if (pos > LEN_OFFSET) begin
      while (pos < BLOCK_BYTES) begin
        blk_bytes[pos] = 8'h00;
        pos++;
      end
      sha_compress();
      pos = 0;
    end
    while (pos < LEN_OFFSET) begin
      blk_bytes[pos] = 8'h00;
      pos++;
    end
    for (k = 0; k < 8; k++) begin
      blk_bytes[LEN_OFFSET + k] = bit_len[63 - 8*k -: 8];
    end
    sha_compress();
    dig = chain_val;
    chain_val = SHA_IV;
    fill_cnt = 0;
    bit_len = '0;
    return 1'b1;
  endfunction

  // offer one byte, with a random gap first, and wait for its transfer
  task automatic put_byte(input logic [7:0] data, input logic fin);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    message_byte_i <= data;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // send a byte and queue the digest words it causes
  task automatic transfer_byte(input logic [7:0] data, input logic fin, input logic known,
                               input logic [0:7][31:0] known_digest);
    logic [0:7][31:0] dig;
    int               i;
    put_byte(data, fin);
    bytes_sent++;
    if (absorb_byte(data, fin, dig)) begin
      messages_done++;
      for (i = 0; i < 8; i++) begin
        pending_words.push_back('{word: known ? known_digest[i] : dig[i],
                                  idx: 3'(i), last_flag: (i == 7)});
      end
    end
  endtask

  // pause the sender until every digest word has come out
  task automatic drain_digests();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // digest word check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d", $time, digest_word_o,
                 word_index_o);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        words_checked++;
        if (digest_word_o !== exp_w.word) begin
          $display("%0t: digest_word mismatch, expected %h, actual %h", $time, exp_w.word,
                   digest_word_o);
          errors++;
        end
        if (word_index_o !== exp_w.idx) begin
          $display("%0t: word_index mismatch, expected %0d, actual %0d", $time, exp_w.idx,
                   word_index_o);
          errors++;
        end
        if (last_word_o !== exp_w.last_flag) begin
          $display("%0t: last_word mismatch, expected %b, actual %b", $time, exp_w.last_flag,
                   last_word_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
      $display("sha256_byte_stream_hasher_test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    stim_row_t   row;
    int          phase;
    int unsigned len;
    int unsigned long_len;
    int unsigned phase_bytes;
    int unsigned k;

    in_valid_i <= 1'b0;
    message_byte_i <= 8'h00;
    final_byte_i <= 1'b0;
    chain_val = SHA_IV;
    fill_cnt = 0;
    bit_len = '0;

    // directed: "abc", single-byte messages at the value extremes and the pad marker value, a mixed-bit message
    directed_rows.push_back('{8'h61, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h62, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h63, 1'b1, 1'b1, ABC_DIGEST});
    directed_rows.push_back('{8'h00, 1'b1, 1'b0, '0});
    directed_rows.push_back('{8'hff, 1'b1, 1'b0, '0});
    directed_rows.push_back('{PAD_BYTE, 1'b1, 1'b0, '0});
    directed_rows.push_back('{8'hff, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'ha5, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h5a, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h01, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hfe, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h7f, 1'b1, 1'b0, '0});

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      transfer_byte(row.data, row.fin, row.known, row.digest);
    end
    drain_digests();

    // random messages: a short one, then, in all but the last phase, one length at a padding
    // boundary (64 fills the block with the final byte, 55 just fits, 56 needs an extra block)
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
          long_len = 64;
          hold_req = 1'b1;
        end
        1: begin
          in_idle_pct = 52;
          out_stall_pct = 0;
          long_len = 55;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 52;
          long_len = 56;
        end
        default: begin
          in_idle_pct = 6;
          out_stall_pct = 6;
          long_len = 0;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < SHORT_BYTES) begin
        len = $urandom_range(4, 1);
        for (k = 0; k < len; k++) begin
          transfer_byte(8'($urandom_range(255)), (k == len - 1), 1'b0, '0);
        end
        phase_bytes += len;
      end
      for (k = 0; k < long_len; k++) begin
        transfer_byte(8'($urandom_range(255)), (k == long_len - 1), 1'b0, '0);
      end
      drain_digests();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d message bytes in %0d messages, incl. lengths 55, 56 and 64,",
             bytes_sent, messages_done);
    $display("with idle, stall and hold-off phases; %0d digest words checked",
             words_checked);
    if (errors == 0) begin
      $display("sha256_byte_stream_hasher_test passed");
    end else begin
      $display("sha256_byte_stream_hasher_test failed");
    end
    $finish;
  end

endmodule
